### hdl/dtff_pkg.sv
// Package for the double to fixed-point (floor) converter.
// Format codes, widths and the shared stage-to-stage struct. No dependencies.
package dtff_pkg;

   localparam int unsigned DblWidth = 64;
   localparam int unsigned FmtWidth = 3;

   typedef enum logic [FmtWidth-1:0] {
      FMT_8_8   = 3'd0,
      FMT_16_16 = 3'd1,
      FMT_17_16 = 3'd2,
      FMT_18_16 = 3'd3,
      FMT_19_16 = 3'd4,
      FMT_32_32 = 3'd5
   } fmt_type;

   // decoded input item as captured by the front register
   typedef struct packed {
      logic        sign;
      logic [10:0] expo;
      logic [51:0] mant;
   } dbl_type;

   // format info handed to the converter
   typedef struct packed {
      logic       known;   // format code is one of the six
      logic       frac32;  // 32 fraction bits, else 16 or 8
      logic       frac8;
      logic [6:0] total;   // total bits
   } fmt_info_type;

   function automatic fmt_info_type fmt_decode(input logic [FmtWidth-1:0] code);
      fmt_info_type r;
      r = '0;
      unique case (code)
         FMT_8_8:   begin r.known = 1'b1; r.frac8  = 1'b1; r.total = 7'd16; end
         FMT_16_16: begin r.known = 1'b1; r.total = 7'd32; end
         FMT_17_16: begin r.known = 1'b1; r.total = 7'd33; end
         FMT_18_16: begin r.known = 1'b1; r.total = 7'd34; end
         FMT_19_16: begin r.known = 1'b1; r.total = 7'd35; end
         FMT_32_32: begin r.known = 1'b1; r.frac32 = 1'b1; r.total = 7'd64; end
         default:   r = '0;
      endcase
      return r;
   endfunction

endpackage

### hdl/dtff_convert.sv
// Combinational floor(value * 2^F) for a captured binary64 and format.
// Depends on dtff_pkg.
module dtff_convert
   import dtff_pkg::*;
(
   input  dbl_type      dbl,
   input  fmt_info_type fmt,
   output logic [63:0]  word,
   output logic         bad
);

   logic [52:0]  sig;
   logic [11:0]  sh;       // biased exponent of value*2^F
   logic [116:0] wide;     // value*2^F with 52 bits below the unit point
   logic [63:0]  ipart;
   logic         lost;     // nonzero bits below unit point
   logic [63:0]  mag_floor;
   logic [63:0]  res;
   logic [63:0]  mask;
   logic         in_range;
   logic [5:0]   fsh;

   always_comb begin
      sig  = {(dbl.expo != 11'd0), dbl.mant};
      fsh  = fmt.frac32 ? 6'd32 : (fmt.frac8 ? 6'd8 : 6'd16);
      // value*2^F = sig * 2^(sh-1075); with the unit point at bit 52 of wide,
      // sig lands at bit (sh - 1023). Below that the magnitude is under one.
      sh = {1'b0, dbl.expo} + {6'd0, fsh};
      if (sh >= 12'd1023 + 12'd64) begin
         wide = '0;   // out of range anyway
      end else if (sh >= 12'd1023) begin
         wide = {64'd0, sig} << (sh - 12'd1023);
      end else begin
         wide = '0;
      end
      ipart = wide[115:52];
      lost  = (wide[51:0] != 52'd0) ||
              ((sh < 12'd1023) && (sig != 53'd0));
      // range check on |value| < 2^31 (or == 2^31 when negative)
      if (dbl.expo < 11'd1054) in_range = 1'b1;
      else if (dbl.expo == 11'd1054 && dbl.sign && dbl.mant == 52'd0) in_range = 1'b1;
      else in_range = 1'b0;
      if (dbl.sign) mag_floor = ipart + {63'd0, lost};
      else          mag_floor = ipart;
      res  = dbl.sign ? (~mag_floor + 64'd1) : mag_floor;
      mask = (fmt.total == 7'd64) ? '1 : ((64'd1 << fmt.total[5:0]) - 64'd1);
      bad  = !(fmt.known && in_range);
      word = bad ? 64'd0 : (res & mask);
   end

endmodule

### hdl/double_to_fixed_floor.sv
// Top level of the double to fixed-point floor converter.
// Depends on dtff_pkg and dtff_convert.
//
// Usage:
//   Input: assert start with req_double_bits; it is taken at that edge
//   (busy is always low, so one item can enter every cycle).
//   Result: rsp_valid pulses for one cycle with rsp_fixed_word and
//   rsp_invalid once the item has passed the input register, then the
//   result register. The receiver cannot stall; results stream at
//   one per cycle with no gaps added.
//   Format: csr_valid/csr_ready write format_select (low 3 bits). csr_ready
//   is always high; write only while no item is in flight.
//   Reset: synchronous active-high reset clears format_select to 8.8 and
//   drops any item in flight.
//   Codes 6 and 7 give zero with invalid set. NaN, infinity and values
//   whose floor leaves the signed 32-bit range give zero with invalid.
module double_to_fixed_floor
   import dtff_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [DblWidth-1:0] req_double_bits,
   output logic                rsp_valid,
   output logic [63:0]         rsp_fixed_word,
   output logic                rsp_invalid,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [63:0]         csr_data
);

   logic [FmtWidth-1:0] fmt_ff;
   logic                v1_ff, v2_ff;
   dbl_type             dbl_ff;
   logic [63:0]         word_ff, word_in;
   logic                bad_ff, bad_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   dtff_convert u_conv (
      .dbl  (dbl_ff),
      .fmt  (fmt_decode(fmt_ff)),
      .word (word_in),
      .bad  (bad_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
      end else begin
         if (csr_valid) fmt_ff <= csr_data[FmtWidth-1:0];
         v1_ff <= start;
         v2_ff <= v1_ff;
      end
      dbl_ff  <= req_double_bits;
      word_ff <= word_in;
      bad_ff  <= bad_in;
   end

   assign rsp_valid      = v2_ff;
   assign rsp_fixed_word = word_ff;
   assign rsp_invalid    = bad_ff;

endmodule

### hdl/dtff_checker.sv
// Port-level checks for double_to_fixed_floor, attached by bind.
// Depends on nothing but the top level's ports.
module dtff_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [63:0] rsp_fixed_word,
   input logic        rsp_invalid
);

   a_lat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("result missing two cycles after start");

   a_noinv: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(start, 2)) |-> $past(reset, 1) || $past(reset, 2))
      else $error("result without start");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid) |-> rsp_fixed_word == 64'd0)
      else $error("invalid result not zero");

endmodule

bind double_to_fixed_floor dtff_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_fixed_word(rsp_fixed_word),
   .rsp_invalid(rsp_invalid)
);
